// File: hdl/rational_arith_unit_macros.svh
// Assertion helpers for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define RAU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rational_arith_unit: same-cycle check failed");

// Next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rational_arith_unit: next-cycle check failed");

`endif

// File: hdl/rau_pkg.sv
package rau_pkg;

    // Default operand width
    localparam int OPERAND_BITS_DEF = 16;
    // Fixed result widths
    localparam int NUM_BITS = 33;
    localparam int DEN_BITS = 32;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic store;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic den_zero;
        logic gcd_done;
        logic div_last;
    } t_status;

endpackage

// File: hdl/rau_ctrl.sv
module rau_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall,
    input  rau_pkg::t_status i_status,
    output rau_pkg::t_cmd   o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (i_status.den_zero) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.store = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// File: hdl/rau_dp.sv
module rau_dp #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  logic                           i_clk,
    input  rau_pkg::t_cmd                  i_cmd,
    input  logic [1:0]                     i_opcode,
    input  logic signed [OPERAND_BITS-1:0] i_a_numerator,
    input  logic signed [OPERAND_BITS-1:0] i_a_denominator,
    input  logic signed [OPERAND_BITS-1:0] i_b_numerator,
    input  logic signed [OPERAND_BITS-1:0] i_b_denominator,
    output rau_pkg::t_status               o_status,
    output logic signed [rau_pkg::NUM_BITS-1:0] o_result_numerator,
    output logic signed [rau_pkg::DEN_BITS-1:0] o_result_denominator,
    output logic                           o_zero_denominator
);

    localparam int PW = 2 * OPERAND_BITS;   // product width
    localparam int SW = PW + 1;             // signed numerator width
    localparam int MW = PW;                 // magnitude width
    localparam int KW = $clog2(MW + 1);
    localparam int CW = $clog2(MW);

    logic [1:0]                     r_op;
    logic signed [OPERAND_BITS-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0]           r_p1, r_p2, r_p3;
    logic signed [SW-1:0]           r_num;
    logic signed [PW-1:0]           r_den;
    logic                           r_num_neg, r_den_neg;
    logic [MW-1:0]                  r_nmag, r_dmag;
    logic [MW-1:0]                  r_u, r_v;
    logic [KW-1:0]                  r_k;
    logic [MW-1:0]                  r_g;
    logic [MW-1:0]                  r_qn, r_qd;
    logic [MW:0]                    r_rn, r_rd;
    logic [CW-1:0]                  r_cnt;
    logic signed [rau_pkg::NUM_BITS-1:0] r_res_num;
    logic signed [rau_pkg::DEN_BITS-1:0] r_res_den;
    logic                           r_zero;

    logic signed [OPERAND_BITS-1:0] w_m1, w_m3;
    logic signed [SW-1:0]           w_sum;
    logic [MW-1:0]                  w_nabs, w_dabs;
    logic [MW:0]                    w_trn, w_trd, w_gx;
    logic signed [SW-1:0]           w_qn_s;
    logic signed [PW:0]             w_qd_s;
    logic signed [63:0]             w_num64, w_den64;

    // Multiplier operand selection
    assign w_m1 = (r_op == rau_pkg::OP_MUL) ? r_bn : r_bd;
    assign w_m3 = (r_op == rau_pkg::OP_DIV) ? r_bn : r_bd;

    // Raw numerator
    always_comb begin
        case (r_op)
            rau_pkg::OP_ADD: w_sum = SW'(r_p1) + SW'(r_p2);
            rau_pkg::OP_SUB: w_sum = SW'(r_p1) - SW'(r_p2);
            default:         w_sum = SW'(r_p1);
        endcase
    end

    assign w_nabs = w_sum[SW-1] ? MW'(-w_sum) : MW'(w_sum);
    assign w_dabs = r_p3[PW-1] ? MW'(-r_p3) : MW'(r_p3);

    // Restoring division trial values, both quotients in step
    assign w_gx  = {1'b0, r_g};
    assign w_trn = {r_rn[MW-1:0], r_qn[MW-1]};
    assign w_trd = {r_rd[MW-1:0], r_qd[MW-1]};

    // Signed reduced values and result formatting
    assign w_qn_s  = r_num_neg ? -$signed({1'b0, r_qn}) : $signed({1'b0, r_qn});
    assign w_qd_s  = r_den_neg ? -$signed({1'b0, r_qd}) : $signed({1'b0, r_qd});
    assign w_num64 = (r_den == '0) ? 64'(r_num) : 64'(w_qn_s);
    assign w_den64 = (r_den == '0) ? 64'(r_den) : 64'(w_qd_s);

    always_ff @(posedge i_clk) begin
        // Operand capture
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_an <= i_a_numerator;
            r_ad <= i_a_denominator;
            r_bn <= i_b_numerator;
            r_bd <= i_b_denominator;
        end
        // Cross products
        if (i_cmd.mul) begin
            r_p1 <= r_an * w_m1;
            r_p2 <= r_bn * r_ad;
            r_p3 <= r_ad * w_m3;
        end
        // Combine, take magnitudes
        if (i_cmd.sum) begin
            r_num     <= w_sum;
            r_den     <= r_p3;
            r_num_neg <= w_sum[SW-1];
            r_den_neg <= r_p3[PW-1];
            r_nmag    <= w_nabs;
            r_dmag    <= w_dabs;
            r_u       <= w_nabs;
            r_v       <= w_dabs;
            r_k       <= '0;
        end
        // Binary gcd step
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
        // Divider set-up
        if (i_cmd.div_init) begin
            r_g   <= MW'(r_v << r_k);
            r_qn  <= r_nmag;
            r_qd  <= r_dmag;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= CW'(MW - 1);
        end
        // One quotient bit of each division
        if (i_cmd.div_step) begin
            if (w_trn >= w_gx) begin
                r_rn <= w_trn - w_gx;
                r_qn <= {r_qn[MW-2:0], 1'b1};
            end else begin
                r_rn <= w_trn;
                r_qn <= {r_qn[MW-2:0], 1'b0};
            end
            if (w_trd >= w_gx) begin
                r_rd <= w_trd - w_gx;
                r_qd <= {r_qd[MW-2:0], 1'b1};
            end else begin
                r_rd <= w_trd;
                r_qd <= {r_qd[MW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CW'(1);
        end
        // Result register
        if (i_cmd.store) begin
            r_res_num <= w_num64[rau_pkg::NUM_BITS-1:0];
            r_res_den <= w_den64[rau_pkg::DEN_BITS-1:0];
            r_zero    <= (r_den == '0);
        end
    end

    assign o_status.den_zero = (r_den == '0);
    assign o_status.gcd_done = (r_u == '0);
    assign o_status.div_last = (r_cnt == '0);

    assign o_result_numerator   = r_res_num;
    assign o_result_denominator = r_res_den;
    assign o_zero_denominator   = r_zero;

endmodule

// File: hdl/rational_arith_unit.sv
// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_stall  i_opcode, i_a_*, i_b_* (OPERAND_BITS each)
// output   out        o_valid / i_stall  o_result_numerator, o_result_denominator,
//                                        o_zero_denominator
//
// One item at a time. Capture, products, combine and check run in order; a zero
// denominator then gives its result at once. Otherwise a binary gcd follows, then
// a bit-serial divider that reduces numerator and denominator together.
// Sync active-low reset returns the sequencer to idle; no clearing pass.
// The result holds while i_stall is high; o_stall stays high until it is taken.
`include "rational_arith_unit_macros.svh"

module rational_arith_unit #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_opcode,
    input  logic signed [OPERAND_BITS-1:0] i_a_numerator,
    input  logic signed [OPERAND_BITS-1:0] i_a_denominator,
    input  logic signed [OPERAND_BITS-1:0] i_b_numerator,
    input  logic signed [OPERAND_BITS-1:0] i_b_denominator,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [rau_pkg::NUM_BITS-1:0] o_result_numerator,
    output logic signed [rau_pkg::DEN_BITS-1:0] o_result_denominator,
    output logic                           o_zero_denominator
);

    rau_pkg::t_cmd    w_cmd;
    rau_pkg::t_status w_status;

    rau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_stall),
        .o_valid  (o_valid)
    );

    rau_dp #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_cmd                (w_cmd),
        .i_opcode             (i_opcode),
        .i_a_numerator        (i_a_numerator),
        .i_a_denominator      (i_a_denominator),
        .i_b_numerator        (i_b_numerator),
        .i_b_denominator      (i_b_denominator),
        .o_status             (w_status),
        .o_result_numerator   (o_result_numerator),
        .o_result_denominator (o_result_denominator),
        .o_zero_denominator   (o_zero_denominator)
    );

    // Checks
    `RAU_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall && !o_valid)
    `RAU_ASSERT_SAME(a_no_accept_while_result, o_valid, o_stall)
    `RAU_ASSERT_SAME(a_zero_flag_den, o_valid && o_zero_denominator, o_result_denominator == '0)

endmodule

// File: sim/rational_arith_unit_test.sv
module rational_arith_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPB = rau_pkg::OPERAND_BITS_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef logic signed [OPB-1:0] t_opnd;

    typedef struct packed {
        logic [rau_pkg::NUM_BITS-1:0] num;
        logic [rau_pkg::DEN_BITS-1:0] den;
        logic                         zden;
    } t_fraction;

    // Reduced-fraction scoreboard
    class fraction_board;
        t_fraction pending[$];
        int        mismatches;
        int        checked;
        int        zero_dens;

        // Work out the reduced fraction for one accepted item
        function void note_item(logic [1:0] op, t_opnd an, t_opnd ad, t_opnd bn, t_opnd bd);
            longint    n, d;
            longint    x, y, r;
            t_fraction f;
            case (op)
                rau_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
                rau_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
                rau_pkg::OP_MUL: begin n = an * bn;           d = ad * bd; end
                default: begin n = an * bd;                   d = ad * bn; end
            endcase
            if (d == 0) begin
                f.zden = 1'b1;
            end else begin
                // Euclid on magnitudes; zero numerator gives |d|
                x = (n < 0) ? -n : n;
                y = (d < 0) ? -d : d;
                while (y != 0) begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                n = n / x;
                d = d / x;
                f.zden = 1'b0;
            end
            f.num = n[rau_pkg::NUM_BITS-1:0];
            f.den = d[rau_pkg::DEN_BITS-1:0];
            pending.push_back(f);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(t_fraction got);
            t_fraction want;
            checked++;
            if (got.zden) zero_dens++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result num=%0d den=%0d zd=%0b",
                             $signed(got.num), $signed(got.den), got.zden);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: exp %0d/%0d zd=%0b, got %0d/%0d zd=%0b",
                             checked, $signed(want.num), $signed(want.den), want.zden,
                             $signed(got.num), $signed(got.den), got.zden);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [1:0]  opcode;
    t_opnd       a_num, a_den, b_num, b_den;
    logic signed [rau_pkg::NUM_BITS-1:0] res_num;
    logic signed [rau_pkg::DEN_BITS-1:0] res_den;
    logic        res_zden;

    fraction_board board;
    int  idle_cycles;
    int  ops_seen[4];

    rational_arith_unit #(.OPERAND_BITS(OPB)) u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_opcode(opcode),
        .i_a_numerator(a_num), .i_a_denominator(a_den),
        .i_b_numerator(b_num), .i_b_denominator(b_den),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_result_numerator(res_num), .o_result_denominator(res_den),
        .o_zero_denominator(res_zden)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Operand picker: half small values, the rest extremes, zeros and full-range randoms
    function automatic t_opnd pick_operand();
        case ($urandom_range(0, 9))
            0: return t_opnd'(0);
            1: return {1'b1, {(OPB-1){1'b0}}};
            2: return {1'b0, {(OPB-1){1'b1}}};
            3, 4: return t_opnd'($urandom);
            default: return t_opnd'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // Present one item and wait for it to be taken; valid drops only for a gap
    task automatic send_item(logic [1:0] op, t_opnd an, t_opnd ad, t_opnd bn, t_opnd bd);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(op, an, ad, bn, bd);
        ops_seen[op]++;
        @(negedge clk);
    endtask

    // Output stall: hold for a drawn number of cycles, then release until taken
    initial begin
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            hold = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Result checker and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                board.check_result({res_num, res_den, res_zden});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_opnd mx, mn;
        mx = {1'b0, {(OPB-1){1'b1}}};
        mn = {1'b1, {(OPB-1){1'b0}}};
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = rau_pkg::OP_ADD;
        a_num = '0; a_den = '0; b_num = '0; b_den = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every operation, extremes, zero numerator and zero denominator
        send_item(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_item(rau_pkg::OP_SUB, 1, 2, 1, 2);
        send_item(rau_pkg::OP_MUL, -3, 4, 2, 9);
        send_item(rau_pkg::OP_DIV, 3, -4, 6, 8);
        send_item(rau_pkg::OP_ADD, mx, mx, mx, mx);
        send_item(rau_pkg::OP_ADD, mn, mn, mn, mn);
        send_item(rau_pkg::OP_SUB, mn, mx, mx, mn);
        send_item(rau_pkg::OP_MUL, mn, mn, mn, mn);
        send_item(rau_pkg::OP_MUL, mx, mn, mn, mx);
        send_item(rau_pkg::OP_DIV, mn, mx, mn, mx);
        send_item(rau_pkg::OP_DIV, mn, 1, mn, 1);
        send_item(rau_pkg::OP_ADD, 0, 5, 0, -7);
        send_item(rau_pkg::OP_MUL, 0, -9, 4, 3);
        send_item(rau_pkg::OP_ADD, 3, 0, 2, 5);
        send_item(rau_pkg::OP_MUL, 1, 2, 3, 0);
        send_item(rau_pkg::OP_DIV, 5, 3, 0, 7);
        send_item(rau_pkg::OP_DIV, 0, 0, 0, 0);
        send_item(rau_pkg::OP_SUB, -1, -1, -1, -1);
        send_item(rau_pkg::OP_ADD, -1, 1, 1, -1);
        send_item(rau_pkg::OP_DIV, 7, 7, -7, -7);

        // Random part
        repeat (1200) begin
            send_item(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d results (%0d with zero denominator)",
                 board.checked, board.zero_dens);
        $display("Ops add/sub/mul/div %0d/%0d/%0d/%0d",
                 ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d expectations left", board.mismatches,
                     board.pending.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
